### hw/rtl/rcpf_pkg.sv
// ----------------------------------------------------------------------------
// rcpf_pkg
// Types and constants of the radio clock pulse framer: payload structs,
// result kinds, register indexes and the nominal pulse length table.
// ----------------------------------------------------------------------------
package rcpf_pkg;

  localparam int unsigned MAX_SYMBOLS = 120;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned IndexW = 7;
  localparam int unsigned ValueW = 5;
  localparam int unsigned TolW   = 6;
  localparam int unsigned CfgW   = 6;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned SpanW  = 11;  // widths of intervals up to the longest window

  localparam logic [TimeW-1:0] MaxIntervalMs = TimeW'(2000);
  localparam int unsigned NumLengths = 9;

  // nominal pulse lengths in ms and the resulting symbol value in tenths
  localparam logic [SpanW-1:0] NominalMs [NumLengths] = '{
    11'd100, 11'd200, 11'd300, 11'd500, 11'd700, 11'd800, 11'd900, 11'd1800, 11'd1900
  };
  localparam logic [ValueW-1:0] NominalVal [NumLengths] = '{
    5'd1, 5'd2, 5'd3, 5'd5, 5'd7, 5'd8, 5'd9, 5'd18, 5'd19
  };

  localparam logic [ValueW-1:0] ValTick    = 5'd1;
  localparam logic [ValueW-1:0] ValMsf     = 5'd5;
  localparam logic [ValueW-1:0] ValWwvb    = 5'd8;
  localparam logic [ValueW-1:0] ValDcfA    = 5'd18;
  localparam logic [ValueW-1:0] ValDcfB    = 5'd19;
  localparam logic [ValueW-1:0] ValZero    = 5'd0;
  localparam logic [ValueW-1:0] DoubleAdd  = 5'd10;

  localparam logic [CfgIdxW-1:0] CfgInvert = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTol    = 1'd1;

  localparam logic [TolW-1:0] TolReset = 6'd40;

  typedef enum logic [2:0] {
    KindWrite  = 3'd0,
    KindUpdate = 3'd1,
    KindMsf    = 3'd2,
    KindWwvb   = 3'd3,
    KindDcf    = 3'd4,
    KindClear  = 3'd5,
    KindSecond = 3'd6
  } kind_e;

  typedef struct packed {
    logic             level;
    logic [TimeW-1:0] time_ms;
  } in_t;

  typedef struct packed {
    kind_e             kind;
    logic [IndexW-1:0] index;
    logic [ValueW-1:0] value;
    logic [TimeW-1:0]  event_time;
    logic              last;
  } out_t;

endpackage

### hw/rtl/radio_clock_pulse_framer.sv
// ----------------------------------------------------------------------------
// radio_clock_pulse_framer
// Classifies receiver level changes by pulse width and emits symbol, frame,
// clear and second-start results for MSF, WWVB and DCF77 time signals.
// ----------------------------------------------------------------------------
// Each accepted edge is classified and turned into its results in the cycle
// it is taken; the results (zero to three) land in a three-entry result queue
// that drives the output one result per cycle unless out_stall_i is high. Edges
// that cause at most one result can be taken back to back while the output
// keeps up; an edge with more results holds the input until the single result
// port has drained all but the last. Samples without a level change are
// accepted and dropped. Configuration is applied at the next accepted edge.
module radio_clock_pulse_framer #(
  parameter int unsigned MaxSymbols = rcpf_pkg::MAX_SYMBOLS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rcpf_pkg::in_t                 in_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rcpf_pkg::out_t                out_o,

  input  logic                          cfg_we_i,
  input  logic [rcpf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rcpf_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int unsigned IW = rcpf_pkg::IndexW;
  localparam int unsigned VW = rcpf_pkg::ValueW;
  localparam logic [IW-1:0] MaxCount = IW'(MaxSymbols);

  // configuration
  logic                     invert_q;
  logic [rcpf_pkg::TolW-1:0] tol_q;

  // framer state
  logic                          held_q, held_d;
  logic [rcpf_pkg::TimeW-1:0]    last_time_q;
  logic [IW-1:0]                 count_q, count_d;
  logic [VW-1:0]                 last_sym_q, last_sym_d;
  logic                          flag_q, flag_d;

  // result queue
  rcpf_pkg::out_t slot_q [3];
  logic [1:0]     fill_q;

  rcpf_pkg::out_t res [3];
  logic [1:0]     res_n;

  logic                       accept, pop;
  logic                       lvl;
  logic [rcpf_pkg::TimeW-1:0] delta;
  logic                       sym_ok;
  logic [VW-1:0]              sym;
  logic [IW-1:0]              base;
  logic                       full;

  function automatic rcpf_pkg::out_t mk(rcpf_pkg::kind_e k, logic [IW-1:0] idx,
                                        logic [VW-1:0] v, logic [rcpf_pkg::TimeW-1:0] t);
    rcpf_pkg::out_t r;
    r.kind       = k;
    r.index      = idx;
    r.value      = v;
    r.event_time = t;
    r.last       = 1'b0;
    return r;
  endfunction

  assign pop         = out_valid_o && !out_stall_i;
  assign in_stall_o  = !((fill_q == 2'd0) || ((fill_q == 2'd1) && !out_stall_i));
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (fill_q != 2'd0);
  assign out_o       = slot_q[0];

  assign lvl   = in_i.level ^ invert_q;
  assign delta = in_i.time_ms - last_time_q;
  assign full  = (count_q >= MaxCount);

  // pulse width classification, first window in table order wins
  always_comb begin
    logic [rcpf_pkg::SpanW-1:0] d11;
    logic [rcpf_pkg::SpanW-1:0] lo, hi;
    d11    = delta[rcpf_pkg::SpanW-1:0];
    sym_ok = 1'b0;
    sym    = rcpf_pkg::ValZero;
    for (int i = rcpf_pkg::NumLengths - 1; i >= 0; i--) begin
      lo = rcpf_pkg::NominalMs[i] - rcpf_pkg::SpanW'(tol_q);
      hi = rcpf_pkg::NominalMs[i] + rcpf_pkg::SpanW'(tol_q);
      if (d11 > lo && d11 < hi) begin
        sym_ok = 1'b1;
        sym    = rcpf_pkg::NominalVal[i];
      end
    end
    if (delta > rcpf_pkg::MaxIntervalMs) begin
      sym_ok = 1'b0;
    end
  end

  // result generation and next state
  always_comb begin
    logic [rcpf_pkg::TimeW-1:0] t;
    t          = in_i.time_ms;
    held_d     = held_q;
    count_d    = count_q;
    last_sym_d = last_sym_q;
    flag_d     = flag_q;
    res_n      = 2'd0;
    base       = count_q;
    for (int i = 0; i < 3; i++) begin
      res[i] = mk(rcpf_pkg::KindClear, '0, '0, t);
    end

    if (lvl != held_q) begin
      held_d = lvl;
      if (!sym_ok) begin
        count_d = '0;
        res[0]  = mk(rcpf_pkg::KindClear, '0, '0, t);
        res_n   = 2'd1;
      end else if (lvl) begin
        if (full) begin
          base   = '0;
          res[0] = mk(rcpf_pkg::KindClear, '0, '0, t);
          res_n  = 2'd1;
        end
        if (flag_q && sym == rcpf_pkg::ValTick) begin
          // second half of a double pulse marks the previous symbol
          flag_d  = 1'b0;
          count_d = base;
          if (base != '0) begin
            last_sym_d = last_sym_q + rcpf_pkg::DoubleAdd;
            res[res_n] = mk(rcpf_pkg::KindUpdate, base - IW'(1), last_sym_d, t);
            res_n      = res_n + 2'd1;
          end
        end else begin
          if (sym == rcpf_pkg::ValMsf || sym == rcpf_pkg::ValWwvb) begin
            res[res_n] = mk((sym == rcpf_pkg::ValMsf) ? rcpf_pkg::KindMsf
                                                      : rcpf_pkg::KindWwvb, base, '0, t);
            res_n      = res_n + 2'd1;
            base       = '0;
          end
          res[res_n] = mk(rcpf_pkg::KindWrite, base, sym, t);
          res_n      = res_n + 2'd1;
          last_sym_d = sym;
          count_d    = base + IW'(1);
        end
      end else begin
        if (count_q > IW'(1) && last_sym_q == rcpf_pkg::ValTick &&
            sym == rcpf_pkg::ValTick) begin
          flag_d = 1'b1;
        end else if (sym == rcpf_pkg::ValDcfA || sym == rcpf_pkg::ValDcfB) begin
          if (full) begin
            base   = '0;
            res[0] = mk(rcpf_pkg::KindClear, '0, '0, t);
            res_n  = 2'd1;
          end
          res[res_n]        = mk(rcpf_pkg::KindWrite, base, rcpf_pkg::ValZero, t);
          res[res_n + 2'd1] = mk(rcpf_pkg::KindDcf, base + IW'(1), '0, t);
          res_n             = res_n + 2'd2;
          last_sym_d        = rcpf_pkg::ValZero;
          count_d           = '0;
        end else begin
          res[0] = mk(rcpf_pkg::KindSecond, '0, '0, t);
          res_n  = 2'd1;
        end
      end
      if (res_n != 2'd0) begin
        res[res_n - 2'd1].last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q    <= 1'b0;
      tol_q       <= rcpf_pkg::TolReset;
      held_q      <= 1'b0;
      last_time_q <= '0;
      count_q     <= '0;
      last_sym_q  <= '0;
      flag_q      <= 1'b0;
      fill_q      <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rcpf_pkg::CfgInvert: invert_q <= cfg_data_i[0];
          rcpf_pkg::CfgTol:    tol_q    <= cfg_data_i[rcpf_pkg::TolW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        fill_q <= res_n;
        if (lvl != held_q) begin
          held_q      <= held_d;
          last_time_q <= in_i.time_ms;
          count_q     <= count_d;
          last_sym_q  <= last_sym_d;
          flag_q      <= flag_d;
        end
      end else if (pop) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q[0] <= res[0];
      slot_q[1] <= res[1];
      slot_q[2] <= res[2];
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
      slot_q[1] <= slot_q[2];
    end
  end

endmodule
